// File: rtl/split_virtqueue_driver_side_assert.svh
// assertion macros for the split virtqueue driver side
`ifndef SPLIT_VIRTQUEUE_DRIVER_SIDE_ASSERT_SVH
`define SPLIT_VIRTQUEUE_DRIVER_SIDE_ASSERT_SVH

// same-cycle implication
`define SVQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SVQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/svq_pkg.sv
`timescale 1ns / 1ps

package svq_pkg;

	localparam int QSIZE_DEF = 256;
	localparam logic [15:0] CHAIN_END = 16'h8000;
	localparam logic [8:0] ADDED_MAX = 9'd511;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_POST    = 2'd1,
		OP_RECLAIM = 2'd2,
		OP_NOTIFY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_NO_USED = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

endpackage

// File: rtl/split_virtqueue_driver_side.sv
`timescale 1ns / 1ps
// a request accepted in S_IDLE executes in S_EXEC, and its result is registered in the
// output register when it commits; a new request is accepted only back in S_IDLE, after
// the read and write-back of the free-list next memory (one port each) around the free head
// a result waiting at the output does not block acceptance, it stalls only the commit
// reset: asynchronous, clears all control registers, then S_CLEAR walks every slot once to
// rebuild the free-list chain before the first request is accepted

module split_virtqueue_driver_side #(
	parameter int QSIZE = svq_pkg::QSIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// buf_addr, buf_len, buf_flags, done_id, done_len
	input  logic [151:0] s_axis_tdata,
	// op
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// status, desc_index, used_len, free_count, added_count, zero fill
	output logic [63:0]  m_axis_tdata
);

	localparam int AW = (QSIZE > 1) ? $clog2(QSIZE) : 1;
	localparam int IW = (AW > 8) ? AW : 8;
	localparam int CW = $clog2(QSIZE + 1);
	localparam logic [AW-1:0] SLOT_LAST = AW'(QSIZE - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QSIZE);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	logic [63:0] desc_addr_mem [QSIZE];
	logic [31:0] desc_len_mem [QSIZE];
	logic [15:0] desc_flags_mem [QSIZE];
	logic [15:0] desc_next_mem [QSIZE];
	logic [7:0]  avail_ring_mem [QSIZE];
	logic [7:0]  used_id_mem [QSIZE];
	logic [31:0] used_len_mem [QSIZE];

	logic [AW-1:0] clr_idx_q;
	logic [15:0]   list_head_q;
	logic [CW-1:0] free_cnt_q;
	logic [AW-1:0] avail_slot_q;
	logic [15:0]   used_wr_q;
	logic [15:0]   last_used_q;
	logic [AW-1:0] used_slot_q;
	logic [AW-1:0] last_slot_q;
	logic [8:0]    added_cnt_q;

	svq_pkg::op_t op_s1;
	logic [63:0]  buf_addr_s1;
	logic [31:0]  buf_len_s1;
	logic [15:0]  buf_flags_s1;
	logic [7:0]   done_id_s1;
	logic [31:0]  done_len_s1;
	logic [15:0]  next_rd_s1;
	logic [7:0]   id_rd_s1;
	logic [31:0]  len_rd_s1;

	logic        out_valid_q;
	logic [63:0] out_data_q;

	logic           accept;
	logic           commit;
	logic           add_ok;
	logic           post_ok;
	logic           rc_ok;
	logic [15:0]    used_fill;
	logic [AW-1:0]  head_slot;
	logic [AW-1:0]  rc_desc;
	logic           nx_we;
	logic [AW-1:0]  nx_waddr;
	logic [15:0]    nx_wdata;

	svq_pkg::status_t res_status;
	logic [IW-1:0]    res_dix;
	logic [31:0]      res_ulen;
	logic [CW-1:0]    res_free;
	logic [8:0]       res_added;
	logic [8:0]       added_inc;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign commit = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);

	assign head_slot = list_head_q[AW-1:0];
	assign rc_desc = AW'(IW'(id_rd_s1));
	assign used_fill = used_wr_q - last_used_q;
	assign added_inc = (added_cnt_q < svq_pkg::ADDED_MAX) ? added_cnt_q + 9'd1 : added_cnt_q;

	assign add_ok = (op_s1 == svq_pkg::OP_ADD) && (free_cnt_q != '0)
		&& (list_head_q < 16'(QSIZE));
	assign post_ok = (op_s1 == svq_pkg::OP_POST) && ({1'b0, used_fill} < 17'(QSIZE));
	assign rc_ok = (op_s1 == svq_pkg::OP_RECLAIM) && (used_wr_q != last_used_q);

	always_comb begin
		res_status = svq_pkg::ST_OK;
		res_dix = '0;
		res_ulen = '0;
		res_free = free_cnt_q;
		res_added = added_cnt_q;
		case (op_s1)
			svq_pkg::OP_ADD: begin
				if (add_ok) begin
					res_dix = IW'(head_slot);
					res_free = free_cnt_q - CW'(1);
					res_added = added_inc;
				end else begin
					res_status = svq_pkg::ST_NO_FREE;
				end
			end
			svq_pkg::OP_POST: begin
				if (!post_ok) begin
					res_status = svq_pkg::ST_FULL;
				end
			end
			svq_pkg::OP_RECLAIM: begin
				if (rc_ok) begin
					res_dix = IW'(rc_desc);
					res_ulen = len_rd_s1;
					res_free = (free_cnt_q < CNT_FULL) ? free_cnt_q + CW'(1) : free_cnt_q;
				end else begin
					res_status = svq_pkg::ST_NO_USED;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		nx_we = 1'b0;
		nx_waddr = head_slot;
		nx_wdata = '0;
		if (state_q == S_CLEAR) begin
			nx_we = 1'b1;
			nx_waddr = clr_idx_q;
			nx_wdata = (clr_idx_q == SLOT_LAST) ? svq_pkg::CHAIN_END : 16'(clr_idx_q) + 16'd1;
		end else if (commit && add_ok) begin
			nx_we = 1'b1;
		end else if (commit && rc_ok) begin
			nx_we = 1'b1;
			nx_waddr = rc_desc;
			nx_wdata = list_head_q;
		end
	end

	// free-list next memory
	always_ff @(posedge clk) begin
		if (nx_we) begin
			desc_next_mem[nx_waddr] <= nx_wdata;
		end
		if (accept) begin
			next_rd_s1 <= desc_next_mem[head_slot];
		end
	end

	// used ring
	always_ff @(posedge clk) begin
		if (commit && post_ok) begin
			used_id_mem[used_slot_q] <= done_id_s1;
			used_len_mem[used_slot_q] <= done_len_s1;
		end
		if (accept) begin
			id_rd_s1 <= used_id_mem[last_slot_q];
			len_rd_s1 <= used_len_mem[last_slot_q];
		end
	end

	// descriptor table and avail ring
	always_ff @(posedge clk) begin
		if (commit && add_ok) begin
			desc_addr_mem[head_slot] <= buf_addr_s1;
			desc_len_mem[head_slot] <= buf_len_s1;
			desc_flags_mem[head_slot] <= buf_flags_s1;
			avail_ring_mem[avail_slot_q] <= 8'(IW'(head_slot));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= svq_pkg::op_t'(s_axis_tuser);
			buf_addr_s1 <= s_axis_tdata[63:0];
			buf_len_s1 <= s_axis_tdata[95:64];
			buf_flags_s1 <= s_axis_tdata[111:96];
			done_id_s1 <= s_axis_tdata[119:112];
			done_len_s1 <= s_axis_tdata[151:120];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_idx_q <= '0;
			list_head_q <= '0;
			free_cnt_q <= CNT_FULL;
			avail_slot_q <= '0;
			used_wr_q <= '0;
			last_used_q <= '0;
			used_slot_q <= '0;
			last_slot_q <= '0;
			added_cnt_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (clr_idx_q == SLOT_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
						free_cnt_q <= res_free;
						if (add_ok) begin
							list_head_q <= next_rd_s1;
							avail_slot_q <= (avail_slot_q == SLOT_LAST) ? '0
								: avail_slot_q + AW'(1);
							added_cnt_q <= added_inc;
						end
						if (post_ok) begin
							used_wr_q <= used_wr_q + 16'd1;
							used_slot_q <= (used_slot_q == SLOT_LAST) ? '0
								: used_slot_q + AW'(1);
						end
						if (rc_ok) begin
							list_head_q <= 16'(rc_desc);
							last_used_q <= last_used_q + 16'd1;
							last_slot_q <= (last_slot_q == SLOT_LAST) ? '0
								: last_slot_q + AW'(1);
						end
						if (op_s1 == svq_pkg::OP_NOTIFY) begin
							added_cnt_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
					clr_idx_q <= '0;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {4'd0, res_added, 9'(res_free), res_ulen, res_dix[7:0], res_status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// File: rtl/svq_checker.sv
`timescale 1ns / 1ps
`include "split_virtqueue_driver_side_assert.svh"

module svq_checker #(
	parameter int QSIZE = svq_pkg::QSIZE_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [151:0] s_axis_tdata,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [63:0]  m_axis_tdata
);

	logic free_in_range;
	logic in_req;

	assign in_req = s_axis_tvalid && s_axis_tready;
	assign free_in_range = (QSIZE > 511) || ({23'd0, m_axis_tdata[50:42]} <= 32'(QSIZE));

	`SVQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	`SVQ_ASSERT_NEXT(a_one_in_flight, in_req, !s_axis_tready, "request taken back to back")

	`SVQ_ASSERT_NOW(a_free_range, m_axis_tvalid, free_in_range, "free count above queue size")

	`SVQ_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tdata[1:0] == svq_pkg::ST_NO_FREE ||
		m_axis_tdata[1:0] == svq_pkg::ST_NO_USED), m_axis_tdata[41:2] == 40'd0,
		"failed request returned data")

endmodule

bind split_virtqueue_driver_side svq_checker #(.QSIZE(QSIZE)) u_svq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata(s_axis_tdata),
	.s_axis_tuser(s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
